>>> rtl/swmd_pkg.sv
package swmd_pkg;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_DELMID = 2'd2;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] data_in;
  } req_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic signed [31:0] middle_value;
    logic               is_empty;
    logic [4:0]         entry_count;
    logic [1:0]         error_code;
  } rsp_t;

  typedef struct packed {
    logic       latch;
    logic       push;
    logic       dec;
    logic       err_we;
    logic [1:0] err_code;
    logic       mid_start;
    logic       shift_rd;
    logic       shift_wr;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       full;
    logic       empty;
    logic       shift_done;
    logic       out_free;
  } dp_status_t;

endpackage

>>> rtl/swmd_ram.sv
module swmd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/swmd_ctrl.sv
module swmd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  swmd_pkg::dp_status_t status,
  output swmd_pkg::dp_cmd_t    cmd
);
  import swmd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_SH_RD = 6'b000100,
    S_SH_WR = 6'b001000,
    S_READ  = 6'b010000,
    S_LOAD  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.err_we   = 1'b1;
        cmd.err_code = ERR_OK;
        state_next   = S_READ;
        unique case (status.func)
          OP_PUSH: begin
            if (status.full) begin
              cmd.err_code = ERR_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end
          OP_POP: begin
            if (status.empty) begin
              cmd.err_code = ERR_EMPTY;
            end else begin
              cmd.dec = 1'b1;
            end
          end
          OP_DELMID: begin
            if (status.empty) begin
              cmd.err_code = ERR_EMPTY;
            end else begin
              cmd.mid_start = 1'b1;
              state_next    = S_SH_RD;
            end
          end
          default: begin
          end
        endcase
      end
      S_SH_RD: begin
        if (status.shift_done) begin
          cmd.dec    = 1'b1;
          state_next = S_READ;
        end else begin
          cmd.shift_rd = 1'b1;
          state_next   = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = S_SH_RD;
      end
      S_READ: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/swmd_dp.sv
module swmd_dp #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  swmd_pkg::req_t       req,
  input  swmd_pkg::dp_cmd_t    cmd,
  output swmd_pkg::dp_status_t status,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output swmd_pkg::rsp_t       rsp
);
  import swmd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] to_addr(input logic [CW-1:0] v);
    logic [CW+AW-1:0] w;
    w = (CW + AW)'(v);
    return w[AW-1:0];
  endfunction

  logic [1:0]        func_q;
  logic [31:0]       data_q;
  logic [1:0]        err_q;
  logic [CW-1:0]     cnt;
  logic [AW-1:0]     ptr;
  logic [CW-1:0]     mid_cnt;
  logic [AW-1:0]     top_addr;
  logic [AW-1:0]     mid_addr;
  logic [CW+AW:0]    ptr_inc;
  logic [CW+AW:0]    cnt_wide;
  logic [CW+4:0]     cnt_ext;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [31:0]       wdata;
  logic [AW-1:0]     raddr_a;
  logic [31:0]       rdata_a;
  logic [31:0]       rdata_b;

  assign mid_cnt  = cnt - CW'(1) - (cnt >> 1);
  assign top_addr = to_addr(cnt - CW'(1));
  assign mid_addr = to_addr(mid_cnt);
  assign ptr_inc  = (CW + AW + 1)'(ptr) + (CW + AW + 1)'(1);
  assign cnt_wide = (CW + AW + 1)'(cnt);
  assign cnt_ext  = (CW + 5)'(cnt);

  assign we      = cmd.push | cmd.shift_wr;
  assign waddr   = cmd.shift_wr ? ptr : to_addr(cnt);
  assign wdata   = cmd.shift_wr ? rdata_a : data_q;
  assign raddr_a = cmd.shift_rd ? ptr + AW'(1) : top_addr;

  swmd_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (mid_addr),
    .rdata_b (rdata_b)
  );

  assign status.func       = func_q;
  assign status.full       = (cnt == CW'(DEPTH));
  assign status.empty      = (cnt == '0);
  assign status.shift_done = (ptr_inc >= cnt_wide);
  assign status.out_free   = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q <= req.func;
      data_q <= req.data_in;
    end
    if (cmd.err_we) begin
      err_q <= cmd.err_code;
    end
    if (cmd.mid_start) begin
      ptr <= mid_addr;
    end else if (cmd.shift_wr) begin
      ptr <= ptr + AW'(1);
    end
    if (cmd.load_out) begin
      if (cnt == '0) begin
        rsp.top_value    <= EMPTY_VALUE;
        rsp.middle_value <= EMPTY_VALUE;
        rsp.is_empty     <= 1'b1;
      end else begin
        rsp.top_value    <= rdata_a;
        rsp.middle_value <= rdata_b;
        rsp.is_empty     <= 1'b0;
      end
      rsp.entry_count <= cnt_ext[4:0];
      rsp.error_code  <= err_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.push) begin
        cnt <= cnt + CW'(1);
      end else if (cmd.dec) begin
        cnt <= cnt - CW'(1);
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/stack_with_middle_delete_core.sv
// Bounded stack of DEPTH signed words held in a RAM, which also reports and can remove its
// middle entry (the one floor(n/2) places below the top). Each request item pushes, pops or
// deletes the middle, and yields one response item with the top and middle values, the empty
// flag, the count and an error code. A push, a pop, a refused operation or an unused code
// passes the execute, read and load states before the next request is taken. Deleting
// the middle of a stack with n entries adds shift read and write states, as the floor(n/2)
// entries above the middle move down one at a time through the RAM, a read and a write per
// entry. The response waits in an output register, so the next request is taken meanwhile.
module stack_with_middle_delete_core #(
  parameter int DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  swmd_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output swmd_pkg::rsp_t rsp
);
  import swmd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  swmd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  swmd_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

>>> rtl/swmd_checker.sv
module swmd_checker #(
  parameter int DEPTH = 16
) (
  input logic           clk,
  input logic           rst,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input swmd_pkg::rsp_t rsp
);
  import swmd_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("Response item changed while stalled.");

  a_empty_values: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.is_empty |->
      rsp.top_value == EMPTY_VALUE && rsp.middle_value == EMPTY_VALUE
      && rsp.entry_count == 5'd0)
    else $error("Empty stack reported with entry values or a count.");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && DEPTH < 32 |-> rsp.is_empty == (rsp.entry_count == 5'd0))
    else $error("Empty flag disagrees with entry count.");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.error_code == ERR_FULL |-> !rsp.is_empty)
    else $error("Push refused as full on an empty stack.");

  a_empty_err: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.error_code == ERR_EMPTY |-> rsp.is_empty)
    else $error("Empty error reported on a stack that holds entries.");

endmodule

bind stack_with_middle_delete_core swmd_checker #(.DEPTH(DEPTH)) u_swmd_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
